// ===== src/bspq_pkg.sv =====
package bspq_pkg;

  localparam logic [8:0] STOP_BIT   = 9'h100;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;

  typedef enum logic [1:0] {
    CMD_PUT = 2'd0,
    CMD_GET = 2'd1,
    CMD_TXE = 2'd2,
    CMD_RX  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_SEND_NOW,
    OP_QUEUE,
    OP_GET,
    OP_TXE,
    OP_RX
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
    logic       newline;
  } op_t;

  typedef struct packed {
    logic       send_valid;
    logic [8:0] send_word;
    logic       get_valid;
    logic [7:0] get_byte;
    logic       dropped;
  } result_t;

endpackage

// ===== src/bspq_if.sv =====
interface bspq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;
  logic       tx_idle;

  modport source (output valid, output cmd, output data_byte, output tx_idle, input ready);
  modport sink   (input valid, input cmd, input data_byte, input tx_idle, output ready);
endinterface

interface bspq_out_if;
  logic       valid;
  logic       ready;
  logic       send_valid;
  logic [8:0] send_word;
  logic       get_valid;
  logic [7:0] get_byte;
  logic       dropped;

  modport source (output valid, output send_valid, output send_word, output get_valid,
                  output get_byte, output dropped, input ready);
  modport sink   (input valid, input send_valid, input send_word, input get_valid,
                  input get_byte, input dropped, output ready);
endinterface

// ===== src/buffered_serial_port_queues_core.sv =====
// A request passes the front request queue, then the back end registers its result;
// a queued newline put first adds a carriage return push, a nonempty pop a registered read
// 1 request per cycle for single-step requests while the output is not stalled; those
// with a second step (carriage return push or registered read) hold off the next request
// reset: synchronous active-low rst_n empties both queues and the request queue;
// queue memories are not cleared and need no clearing pass
module buffered_serial_port_queues_core
  import bspq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 512
) (
  input  logic       clk,
  input  logic       rst_n,
  bspq_in_if.sink    in_ch,
  bspq_out_if.source out_ch
);

  logic op_valid;
  logic op_ready;
  op_t  op;

  bspq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .op_valid (op_valid),
    .op       (op),
    .op_ready (op_ready)
  );

  bspq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op       (op),
    .op_ready (op_ready),
    .out_ch   (out_ch)
  );

endmodule

// ===== src/bspq_front.sv =====
module bspq_front
  import bspq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  bspq_in_if.sink    in_ch,
  output logic       op_valid,
  output op_t        op,
  input  logic       op_ready
);

  op_t        fifo_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  op_t        op_new;
  logic       push, pop;

  always_comb begin
    op_new.data    = in_ch.data_byte;
    op_new.newline = 1'b0;
    case (cmd_t'(in_ch.cmd))
      CMD_PUT: begin
        op_new.kind    = in_ch.tx_idle ? OP_SEND_NOW : OP_QUEUE;
        op_new.newline = (in_ch.data_byte == CH_NEWLINE);
      end
      CMD_GET: op_new.kind = OP_GET;
      CMD_TXE: op_new.kind = OP_TXE;
      CMD_RX:  op_new.kind = OP_RX;
      default: op_new.kind = OP_RX;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign op_valid    = (cnt_r != 2'd0);
  assign op          = fifo_r[rd_ptr_r];
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = op_valid && op_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= op_new;
  end

endmodule

// ===== src/bspq_back.sv =====
module bspq_back
  import bspq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 512
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       op_valid,
  input  op_t        op,
  output logic       op_ready,
  bspq_out_if.source out_ch
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CR,
    ST_RD
  } state_t;

  state_t     state_r, state_nxt;
  logic       rd_recv_r, rd_recv_nxt;
  logic       out_valid_r, out_valid_nxt;
  result_t    res_r, res_nxt;

  logic [PTR_W-1:0] s_head_r, s_head_nxt, s_tail_r, s_tail_nxt;
  logic [PTR_W-1:0] r_head_r, r_head_nxt, r_tail_r, r_tail_nxt;
  logic [CNT_W-1:0] s_cnt_r, s_cnt_nxt, r_cnt_r, r_cnt_nxt;

  logic [7:0] send_mem [QUEUE_DEPTH];
  logic [7:0] recv_mem [QUEUE_DEPTH];
  logic [7:0] s_rd_r, r_rd_r;
  logic       s_we, s_re, r_we, r_re;
  logic [7:0] s_wdata;
  logic       take;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign take     = (state_r == ST_IDLE) && op_valid && (!out_valid_r || out_ch.ready);
  assign op_ready = take;

  always_comb begin
    state_nxt     = state_r;
    rd_recv_nxt   = rd_recv_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    res_nxt       = res_r;
    s_head_nxt    = s_head_r;
    s_tail_nxt    = s_tail_r;
    s_cnt_nxt     = s_cnt_r;
    r_head_nxt    = r_head_r;
    r_tail_nxt    = r_tail_r;
    r_cnt_nxt     = r_cnt_r;
    s_we          = 1'b0;
    s_re          = 1'b0;
    r_we          = 1'b0;
    r_re          = 1'b0;
    s_wdata       = op.data;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          res_nxt = '0;
          case (op.kind)
            OP_SEND_NOW: begin
              res_nxt.send_valid = 1'b1;
              res_nxt.send_word  = STOP_BIT | {1'b0, op.data};
              out_valid_nxt      = 1'b1;
              if (op.newline) begin
                s_wdata = CH_RETURN;
                if (s_cnt_r == CNT_FULL) begin
                  res_nxt.dropped = 1'b1;
                end else begin
                  s_we       = 1'b1;
                  s_tail_nxt = ring_next(s_tail_r);
                  s_cnt_nxt  = s_cnt_r + CNT_W'(1);
                end
              end
            end
            OP_QUEUE: begin
              if (s_cnt_r == CNT_FULL) begin
                res_nxt.dropped = 1'b1;
              end else begin
                s_we       = 1'b1;
                s_tail_nxt = ring_next(s_tail_r);
                s_cnt_nxt  = s_cnt_r + CNT_W'(1);
              end
              if (op.newline) state_nxt = ST_CR;
              else out_valid_nxt = 1'b1;
            end
            OP_GET: begin
              if (r_cnt_r != '0) begin
                r_re        = 1'b1;
                r_head_nxt  = ring_next(r_head_r);
                r_cnt_nxt   = r_cnt_r - CNT_W'(1);
                rd_recv_nxt = 1'b1;
                state_nxt   = ST_RD;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            OP_TXE: begin
              if (s_cnt_r != '0) begin
                s_re        = 1'b1;
                s_head_nxt  = ring_next(s_head_r);
                s_cnt_nxt   = s_cnt_r - CNT_W'(1);
                rd_recv_nxt = 1'b0;
                state_nxt   = ST_RD;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            OP_RX: begin
              if (r_cnt_r == CNT_FULL) begin
                res_nxt.dropped = 1'b1;
              end else begin
                r_we       = 1'b1;
                r_tail_nxt = ring_next(r_tail_r);
                r_cnt_nxt  = r_cnt_r + CNT_W'(1);
              end
              out_valid_nxt = 1'b1;
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      ST_CR: begin
        s_wdata = CH_RETURN;
        if (s_cnt_r == CNT_FULL) begin
          res_nxt.dropped = 1'b1;
        end else begin
          s_we       = 1'b1;
          s_tail_nxt = ring_next(s_tail_r);
          s_cnt_nxt  = s_cnt_r + CNT_W'(1);
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_RD: begin
        if (rd_recv_r) begin
          res_nxt.get_valid = 1'b1;
          res_nxt.get_byte  = r_rd_r;
        end else begin
          res_nxt.send_valid = 1'b1;
          res_nxt.send_word  = STOP_BIT | {1'b0, s_rd_r};
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_recv_r   <= 1'b0;
      out_valid_r <= 1'b0;
      s_head_r    <= '0;
      s_tail_r    <= '0;
      s_cnt_r     <= '0;
      r_head_r    <= '0;
      r_tail_r    <= '0;
      r_cnt_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_recv_r   <= rd_recv_nxt;
      out_valid_r <= out_valid_nxt;
      s_head_r    <= s_head_nxt;
      s_tail_r    <= s_tail_nxt;
      s_cnt_r     <= s_cnt_nxt;
      r_head_r    <= r_head_nxt;
      r_tail_r    <= r_tail_nxt;
      r_cnt_r     <= r_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (s_we) send_mem[s_tail_r] <= s_wdata;
    if (s_re) s_rd_r <= send_mem[s_head_r];
  end

  always_ff @(posedge clk) begin
    if (r_we) recv_mem[r_tail_r] <= op.data;
    if (r_re) r_rd_r <= recv_mem[r_head_r];
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.send_valid = res_r.send_valid;
  assign out_ch.send_word  = res_r.send_word;
  assign out_ch.get_valid  = res_r.get_valid;
  assign out_ch.get_byte   = res_r.get_byte;
  assign out_ch.dropped    = res_r.dropped;

endmodule

// ===== src/bspq_checker.sv =====
module bspq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       send_valid,
  input logic [8:0] send_word,
  input logic       get_valid,
  input logic [7:0] get_byte
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(send_valid && get_valid))
    else $error("send and get in one result");

  a_send_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (send_word[8] == send_valid) && (send_valid || send_word == 9'd0))
    else $error("send word does not match send valid");

  a_get_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !get_valid |-> get_byte == 8'd0)
    else $error("get byte set without get valid");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind buffered_serial_port_queues_core bspq_checker u_bspq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .send_valid (out_ch.send_valid),
  .send_word  (out_ch.send_word),
  .get_valid  (out_ch.get_valid),
  .get_byte   (out_ch.get_byte)
);
